// ===== sv/voxel_ray_traversal_assert.svh =====
// assertion macros for the voxel ray traversal block
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`ifndef SYNTH
`define VRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VRT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRT_ASSERT(label, clk, rst_n, prop, msg)
`define VRT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== sv/vrt_pkg.sv =====
// shared types and constants for the voxel ray traversal block
`timescale 1ns / 1ps
package vrt_pkg;
    localparam int CHUNK_WIDTH_LOG2_DEF = 4;
    localparam int CHUNK_DEPTH_LOG2_DEF = 4;
    localparam int T_FRACTION_BITS_DEF  = 16;
    localparam logic [7:0] MAX_DISTANCE_RESET = 8'd12;

    localparam logic [1:0] RK_QUERY = 2'd0;
    localparam logic [1:0] RK_HIT   = 2'd1;
    localparam logic [1:0] RK_MISS  = 2'd2;

    localparam logic [2:0] FACE_LEFT   = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_BOTTOM = 3'd2;
    localparam logic [2:0] FACE_TOP    = 3'd3;
    localparam logic [2:0] FACE_FRONT  = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load_ray;    // capture origin, start setup
        logic div_start;   // start divide for div_axis
        logic div_incr;    // 0 first crossing, 1 increment
        logic [1:0] div_axis;
        logic step;        // step along smallest crossing
        logic emit;        // load output register
        logic emit_hit;
    } vrt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic in_limit;
    } vrt_status_t;
endpackage

// ===== sv/vrt_divider.sv =====
// restoring divider, one quotient bit per cycle, saturating to 32 bits
`timescale 1ns / 1ps
module vrt_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [16:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];
endmodule

// ===== sv/vrt_datapath.sv =====
// ray state registers, setup divides, stepping and output register
`timescale 1ns / 1ps
module vrt_datapath
#(
    parameter int CHUNK_WIDTH_LOG2 = vrt_pkg::CHUNK_WIDTH_LOG2_DEF,
    parameter int CHUNK_DEPTH_LOG2 = vrt_pkg::CHUNK_DEPTH_LOG2_DEF,
    parameter int T_FRACTION_BITS  = vrt_pkg::T_FRACTION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  vrt_pkg::vrt_cmd_t   cmd,
    output vrt_pkg::vrt_status_t status,
    input  logic [7:0]          max_distance,
    input  logic [31:0]         in_origin_x,
    input  logic [31:0]         in_origin_y,
    input  logic [31:0]         in_origin_z,
    input  logic [15:0]         in_dir_x,
    input  logic [15:0]         in_dir_y,
    input  logic [15:0]         in_dir_z,
    output logic [1:0]          o_kind,
    output logic [19:0]         o_vx,
    output logic [19:0]         o_vy,
    output logic [19:0]         o_vz,
    output logic [15:0]         o_cx,
    output logic [15:0]         o_cz,
    output logic [2:0]          o_face
);
    import vrt_pkg::*;

    localparam int LIMW = 8 + T_FRACTION_BITS;

    logic [19:0] vox_reg [3];
    logic [11:0] frac_reg [3];
    logic [15:0] dir_reg [3];
    logic [31:0] cross_reg [3];
    logic [31:0] incr_reg [3];
    logic [31:0] dist_reg;
    logic [1:0]  last_reg;
    logic        div_incr_reg;
    logic [1:0]  div_axis_reg;

    logic [15:0] dsel;
    logic [15:0] mag;
    logic [12:0] num;
    logic [63:0] dividend;
    logic        div_done;
    logic [31:0] quotient;
    logic [1:0]  ax;
    logic [32:0] sum;
    logic [LIMW-1:0] limit;
    logic [19:0] vsel;
    logic [2:0]  face;

    assign dsel = dir_reg[cmd.div_axis];
    assign mag  = dsel[15] ? (~dsel) + 16'd1 : dsel;
    assign num  = dsel[15] ? {1'b0, frac_reg[cmd.div_axis]}
                           : 13'd4096 - {1'b0, frac_reg[cmd.div_axis]};
    assign dividend = cmd.div_incr ? (64'd1 << (T_FRACTION_BITS + 14))
                                   : (64'(num) << (T_FRACTION_BITS + 2));

    vrt_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (mag),
        .done     (div_done),
        .quotient (quotient)
    );

    // strict x first, then y, else z
    always_comb
    begin
        if (cross_reg[0] < cross_reg[1] && cross_reg[0] < cross_reg[2])
            ax = AXIS_X;
        else if (cross_reg[1] < cross_reg[2])
            ax = AXIS_Y;
        else
            ax = AXIS_Z;
    end

    assign sum   = {1'b0, cross_reg[ax]} + {1'b0, incr_reg[ax]};
    assign limit = {max_distance, {T_FRACTION_BITS{1'b0}}};
    assign status.div_done = div_done;
    assign status.in_limit = (33'(dist_reg) < 33'(limit));

    always_comb
    begin
        case (last_reg)
            AXIS_X:  face = dir_reg[0][15] ? FACE_RIGHT : FACE_LEFT;
            AXIS_Y:  face = dir_reg[1][15] ? FACE_TOP : FACE_BOTTOM;
            AXIS_Z:  face = dir_reg[2][15] ? FACE_BACK : FACE_FRONT;
            default: face = FACE_FRONT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= AXIS_NONE;
            dist_reg <= '0;
        end
        else if (cmd.load_ray)
        begin
            last_reg <= AXIS_NONE;
            dist_reg <= '0;
        end
        else if (cmd.step)
        begin
            last_reg <= ax;
            dist_reg <= cross_reg[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ray)
        begin
            vox_reg[0]  <= in_origin_x[31:12];
            vox_reg[1]  <= in_origin_y[31:12];
            vox_reg[2]  <= in_origin_z[31:12];
            frac_reg[0] <= in_origin_x[11:0];
            frac_reg[1] <= in_origin_y[11:0];
            frac_reg[2] <= in_origin_z[11:0];
            dir_reg[0]  <= in_dir_x;
            dir_reg[1]  <= in_dir_y;
            dir_reg[2]  <= in_dir_z;
        end
        if (cmd.div_start)
        begin
            div_incr_reg <= cmd.div_incr;
            div_axis_reg <= cmd.div_axis;
        end
        if (div_done)
        begin
            if (dir_reg[div_axis_reg] == 16'd0)
            begin
                cross_reg[div_axis_reg] <= 32'hFFFF_FFFF;
                incr_reg[div_axis_reg]  <= 32'hFFFF_FFFF;
            end
            else if (div_incr_reg)
                incr_reg[div_axis_reg]  <= quotient;
            else
                cross_reg[div_axis_reg] <= quotient;
        end
        if (cmd.step)
        begin
            if (dir_reg[ax] != 16'd0)
                vox_reg[ax] <= dir_reg[ax][15] ? vox_reg[ax] - 20'd1 : vox_reg[ax] + 20'd1;
            cross_reg[ax] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (cmd.emit)
        begin
            if (cmd.emit_hit || status.in_limit)
            begin
                o_kind <= cmd.emit_hit ? RK_HIT : RK_QUERY;
                o_vx   <= vox_reg[0];
                o_vy   <= vox_reg[1];
                o_vz   <= vox_reg[2];
                o_cx   <= 16'(20'($signed(vox_reg[0]) >>> CHUNK_WIDTH_LOG2));
                o_cz   <= 16'(20'($signed(vox_reg[2]) >>> CHUNK_DEPTH_LOG2));
                o_face <= cmd.emit_hit ? face : FACE_LEFT;
            end
            else
            begin
                o_kind <= RK_MISS;
                o_vx   <= '0;
                o_vy   <= '0;
                o_vz   <= '0;
                o_cx   <= '0;
                o_cz   <= '0;
                o_face <= FACE_BACK;
            end
        end
    end
endmodule

// ===== sv/vrt_ctrl.sv =====
// control state machine for ray setup, stepping and output handshake
`timescale 1ns / 1ps
module vrt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic                 in_solid,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vrt_pkg::vrt_cmd_t    cmd,
    input  vrt_pkg::vrt_status_t status
);
    import vrt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_WAIT = 5'b00100,
        S_STEP = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;   // {axis, incr} divide sequence 0..5
    logic        active_reg, active_next;
    logic        ov_reg, ov_next;
    logic        hit_reg, hit_next;
    logic        accept;

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        hit_next    = hit_reg;
        ov_next     = ov_reg && !out_ready;
        cmd         = '0;
        cmd.div_axis = idx_reg[2:1];
        cmd.div_incr = idx_reg[0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_kind)
                    begin
                        cmd.load_ray = 1'b1;
                        idx_next     = '0;
                        active_next  = 1'b1;
                        state_next   = S_DIV;
                    end
                    else if (active_reg)
                    begin
                        hit_next   = in_solid;
                        state_next = in_solid ? S_EMIT : S_STEP;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                begin
                    if (idx_reg == 3'd5)
                    begin
                        hit_next   = 1'b0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_hit = hit_reg;
                ov_next      = 1'b1;
                if (hit_reg || !status.in_limit)
                    active_next = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
            hit_reg    <= hit_next;
        end
    end
endmodule

// ===== sv/voxel_ray_traversal.sv =====
// top level of the voxel ray traversal block
// a new ray runs six divides in turn on the single shared bit-serial divider
//   (each one: start, the quotient bits, done) and then emit
// an air answer goes from accept through step, emit and the output register
// a solid answer skips the step; one word is in flight at a time
// reset: asynchronous active low, clears control state and sets max_distance to 12
`timescale 1ns / 1ps
`include "voxel_ray_traversal_assert.svh"
module voxel_ray_traversal
#(
    parameter int CHUNK_WIDTH_LOG2 = vrt_pkg::CHUNK_WIDTH_LOG2_DEF,
    parameter int CHUNK_DEPTH_LOG2 = vrt_pkg::CHUNK_DEPTH_LOG2_DEF,
    parameter int T_FRACTION_BITS  = vrt_pkg::T_FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [31:0] origin_z,
    input  logic [15:0] dir_x,
    input  logic [15:0] dir_y,
    input  logic [15:0] dir_z,
    input  logic        solid,
    // result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [19:0] voxel_x,
    output logic [19:0] voxel_y,
    output logic [19:0] voxel_z,
    output logic [15:0] chunk_x,
    output logic [15:0] chunk_z,
    output logic [2:0]  face
);
    import vrt_pkg::*;

    logic [7:0]  max_dist_reg;
    vrt_cmd_t    cmd;
    vrt_status_t status;

    // ray length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_dist_reg <= MAX_DISTANCE_RESET;
        else if (cfg_we)
            max_dist_reg <= cfg_wdata;
    end

    // sequencer: setup divides, step, emit
    vrt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (kind),
        .in_solid  (solid),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // ray state and arithmetic
    vrt_datapath
    #(
        .CHUNK_WIDTH_LOG2 (CHUNK_WIDTH_LOG2),
        .CHUNK_DEPTH_LOG2 (CHUNK_DEPTH_LOG2),
        .T_FRACTION_BITS  (T_FRACTION_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .max_distance (max_dist_reg),
        .in_origin_x  (origin_x),
        .in_origin_y  (origin_y),
        .in_origin_z  (origin_z),
        .in_dir_x     (dir_x),
        .in_dir_y     (dir_y),
        .in_dir_z     (dir_z),
        .o_kind       (result_kind),
        .o_vx         (voxel_x),
        .o_vy         (voxel_y),
        .o_vz         (voxel_z),
        .o_cx         (chunk_x),
        .o_cz         (chunk_z),
        .o_face       (face)
    );

    // no new word taken while a result is pending and not being taken
    `VRT_ASSERT(a_no_accept_stalled, clk, rst_n, (out_valid && !out_ready) |-> !in_ready, "accept while stalled")
    // a step and an emit never share a cycle
    `VRT_ASSERT(a_step_emit, clk, rst_n, !(cmd.step && cmd.emit), "step and emit together")
    // emit always raises the output valid
    `VRT_ASSERT(a_emit_valid, clk, rst_n, cmd.emit |=> out_valid, "emit without valid")
endmodule
